// ===== src/tccs_pkg.sv =====
package tccs_pkg;

  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 25;

  localparam int ROW_W  = 6;
  localparam int COL_W  = 8;
  localparam int CELL_W = 16;

  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;
  localparam logic [7:0]        CH_SPACE   = 8'h20;
  localparam logic [7:0]        CH_LF      = 8'd10;
  localparam logic [7:0]        CH_CR      = 8'd13;

  localparam logic [1:0] REG_FG     = 2'd0;
  localparam logic [1:0] REG_BG     = 2'd1;
  localparam logic [1:0] REG_SCROLL = 2'd2;

  typedef enum logic [1:0] {
    ACT_PUT,
    ACT_CLEAR,
    ACT_SETCUR,
    ACT_READ
  } act_t;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_LF,
    OP_CR,
    OP_CLEAR,
    OP_SETCUR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       ch;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_word_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } back_stat_t;

endpackage

// ===== src/tccs_ram.sv =====
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/tccs_front.sv =====
module tccs_front import tccs_pkg::*; #(
  parameter int SCREEN_COLS = DEF_COLS,
  parameter int SCREEN_ROWS = DEF_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_action,
  input  logic [7:0] in_char_code,
  input  logic [4:0] in_target_row,
  input  logic [6:0] in_target_col,
  input  back_stat_t stat,
  output cmd_word_t  word
);

  localparam int RMAX = SCREEN_ROWS - 1;
  localparam int CMAX = SCREEN_COLS - 1;

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       accept;

  always_comb begin
    cls.ch  = in_char_code;
    cls.row = (int'(in_target_row) > RMAX) ? ROW_W'(RMAX) : ROW_W'(in_target_row);
    cls.col = (int'(in_target_col) > CMAX) ? COL_W'(CMAX) : COL_W'(in_target_col);
    unique case (act_t'(in_action))
      ACT_PUT: begin
        if (in_char_code == CH_LF) begin
          cls.op = OP_LF;
        end else if (in_char_code == CH_CR) begin
          cls.op = OP_CR;
        end else begin
          cls.op = OP_CHAR;
        end
      end
      ACT_CLEAR:  cls.op = OP_CLEAR;
      ACT_SETCUR: cls.op = OP_SETCUR;
      ACT_READ:   cls.op = OP_READ;
      default:    cls.op = OP_READ;
    endcase
  end

  assign busy   = (cnt_r == 2'd2) || stat.init_busy;
  assign accept = start && !busy;

  assign word.valid = (cnt_r != 2'd0);
  assign word.cmd   = q_r[rp_r];

  always_comb begin
    wp_nxt  = accept ? !wp_r : wp_r;
    rp_nxt  = stat.pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, accept} - {1'b0, stat.pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (accept) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

// ===== src/tccs_back.sv =====
module tccs_back import tccs_pkg::*; #(
  parameter int SCREEN_COLS = DEF_COLS,
  parameter int SCREEN_ROWS = DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [3:0]        fg_color,
  input  logic [3:0]        bg_color,
  input  logic              scroll_on,
  input  cmd_word_t         word,
  output back_stat_t        stat,
  output logic              out_valid,
  output logic [15:0]       out_read_data,
  output logic [ROW_W-1:0]  cur_row,
  output logic [COL_W-1:0]  cur_col
);

  localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int PW    = $clog2(CELLS + 1);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCROLL,
    S_FILL,
    S_READ
  } state_t;

  state_t            state_r, state_nxt;
  logic [PW-1:0]     ptr_r, ptr_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     wa_r, wa_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              valid_r, valid_nxt;
  logic [15:0]       data_r, data_nxt;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [15:0]       wdata, rdata;
  logic              do_lf, emit, pop;
  logic [15:0]       blank;
  logic [AW-1:0]     cur_addr, tgt_addr;

  tccs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign blank    = {bg_color, fg_color, CH_SPACE};
  assign cur_addr = AW'(int'(row_r) * SCREEN_COLS + int'(col_r));
  assign tgt_addr = AW'(int'(word.cmd.row) * SCREEN_COLS + int'(word.cmd.col));

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    pend_nxt  = 1'b0;
    wa_nxt    = wa_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    valid_nxt = 1'b0;
    data_nxt  = data_r;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    re        = 1'b0;
    raddr     = '0;
    do_lf     = 1'b0;
    emit      = 1'b0;
    pop       = 1'b0;

    unique case (state_r)
      S_INIT: begin
        we    = 1'b1;
        waddr = ptr_r[AW-1:0];
        wdata = RESET_CELL;
        if (ptr_r == PW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
          ptr_nxt   = '0;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (word.valid) begin
          pop = 1'b1;
          unique case (word.cmd.op)
            OP_CHAR: begin
              we    = 1'b1;
              waddr = cur_addr;
              wdata = {bg_color, fg_color, word.cmd.ch};
              if (col_r == COL_W'(SCREEN_COLS - 1)) begin
                do_lf = 1'b1;
              end else begin
                col_nxt = col_r + 1'b1;
                emit    = 1'b1;
              end
            end
            OP_LF: do_lf = 1'b1;
            OP_CR: begin
              col_nxt = '0;
              emit    = 1'b1;
            end
            OP_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              ptr_nxt   = '0;
              state_nxt = S_FILL;
            end
            OP_SETCUR: begin
              row_nxt = word.cmd.row;
              col_nxt = word.cmd.col;
              emit    = 1'b1;
            end
            OP_READ: begin
              re        = 1'b1;
              raddr     = tgt_addr;
              state_nxt = S_READ;
            end
            default: emit = 1'b1;
          endcase
          if (do_lf) begin
            col_nxt = '0;
            if (row_r == ROW_W'(SCREEN_ROWS - 1)) begin
              if (scroll_on) begin
                if (SCREEN_ROWS > 1) begin
                  ptr_nxt   = PW'(SCREEN_COLS);
                  state_nxt = S_SCROLL;
                end else begin
                  ptr_nxt   = '0;
                  state_nxt = S_FILL;
                end
              end else begin
                emit = 1'b1;
              end
            end else begin
              row_nxt = row_r + 1'b1;
              emit    = 1'b1;
            end
          end
          if (emit) begin
            valid_nxt = 1'b1;
            data_nxt  = '0;
          end
        end
      end
      S_SCROLL: begin
        if (pend_r) begin
          we    = 1'b1;
          waddr = wa_r;
          wdata = rdata;
        end
        if (ptr_r == PW'(CELLS)) begin
          ptr_nxt   = PW'((SCREEN_ROWS - 1) * SCREEN_COLS);
          state_nxt = S_FILL;
        end else begin
          re       = 1'b1;
          raddr    = ptr_r[AW-1:0];
          pend_nxt = 1'b1;
          wa_nxt   = AW'(ptr_r - PW'(SCREEN_COLS));
          ptr_nxt  = ptr_r + 1'b1;
        end
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = ptr_r[AW-1:0];
        wdata = blank;
        if (ptr_r == PW'(CELLS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
          valid_nxt = 1'b1;
          data_nxt  = '0;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_READ: begin
        valid_nxt = 1'b1;
        data_nxt  = rdata;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ptr_r   <= '0;
      pend_r  <= 1'b0;
      row_r   <= '0;
      col_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      pend_r  <= pend_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      valid_r <= valid_nxt;
    end
    wa_r   <= wa_nxt;
    data_r <= data_nxt;
  end

  assign stat.pop       = pop;
  assign stat.init_busy = (state_r == S_INIT);
  assign out_valid      = valid_r;
  assign out_read_data  = data_r;
  assign cur_row        = row_r;
  assign cur_col        = col_r;

endmodule

// ===== src/text_console_cursor_scroll.sv =====
// Text console engine: a SCREEN_ROWS x SCREEN_COLS store of 16-bit cells
// (attribute byte above character byte) and a cursor.
// Command channel: a word is taken on a rising edge with start high and
// busy low; in_action selects put character, clear, set cursor or read cell.
// A short command queue sits between the decode front end and the
// execution back end, so up to two words are taken ahead of execution.
// Result channel: one result per command, shown for one cycle with
// out_valid high; the receiver cannot stall, so results are never held.
// out_valid is registered: it rises in the cycle after the back end takes
// a put that does not scroll, a carriage return or a set cursor; a read
// first passes the registered RAM port and the S_READ state. Clear writes
// one cell a cycle. A line feed on the bottom row with scrolling on copies
// one cell a cycle and then blanks the bottom row. The single-port-per-side
// cell RAM sets these rates. After reset the cell RAM is swept to space,
// white on black, one cell a cycle with busy high; configuration writes
// over the APB-style port are taken throughout.
module text_console_cursor_scroll import tccs_pkg::*; #(
  parameter int SCREEN_COLS = DEF_COLS,
  parameter int SCREEN_ROWS = DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_target_row,
  input  logic [6:0]  in_target_col,
  output logic        out_valid,
  output logic [15:0] out_read_data,
  output logic [4:0]  out_cursor_row,
  output logic [6:0]  out_cursor_col,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]       fg_r, fg_nxt;
  logic [3:0]       bg_r, bg_nxt;
  logic             scroll_r, scroll_nxt;
  logic             cfg_wr;
  cmd_word_t        word;
  back_stat_t       stat;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    fg_nxt     = fg_r;
    bg_nxt     = bg_r;
    scroll_nxt = scroll_r;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_FG:     fg_nxt     = pwdata[3:0];
        REG_BG:     bg_nxt     = pwdata[3:0];
        REG_SCROLL: scroll_nxt = pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FG:     prdata = {28'd0, fg_r};
      REG_BG:     prdata = {28'd0, bg_r};
      REG_SCROLL: prdata = {31'd0, scroll_r};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r     <= 4'd15;
      bg_r     <= 4'd0;
      scroll_r <= 1'b1;
    end else begin
      fg_r     <= fg_nxt;
      bg_r     <= bg_nxt;
      scroll_r <= scroll_nxt;
    end
  end

  tccs_front #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_char_code  (in_char_code),
    .in_target_row (in_target_row),
    .in_target_col (in_target_col),
    .stat          (stat),
    .word          (word)
  );

  tccs_back #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .fg_color      (fg_r),
    .bg_color      (bg_r),
    .scroll_on     (scroll_r),
    .word          (word),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .cur_row       (cur_row),
    .cur_col       (cur_col)
  );

  assign out_cursor_row = 5'(cur_row);
  assign out_cursor_col = 7'(cur_col);

endmodule
